>>> rtl/core/mdu_pkg.sv
// Shared types and constants of the HI/LO multiply-divide unit.
`default_nettype none

package mdu_pkg;

   localparam int MDU_WIDTH = 32;
   localparam int MDU_STEPS = 32;
   localparam int MDU_COUNT_WIDTH = $clog2(MDU_STEPS);
   localparam logic [MDU_WIDTH-1:0] MDU_RESET_VALUE = 32'hdeadbeaf;

   typedef enum logic [2:0] {
      OP_MULT  = 3'd0,
      OP_MULTU = 3'd1,
      OP_DIV   = 3'd2,
      OP_DIVU  = 3'd3,
      OP_MFHI  = 3'd4,
      OP_MFLO  = 3'd5,
      OP_MTHI  = 3'd6,
      OP_MTLO  = 3'd7
   } mdu_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_FIX  = 2'd2
   } mdu_state_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic start;
      logic step;
      logic is_div;
      logic is_signed;
   } mdu_ctrl_type;

   // Datapath to sequencer status
   typedef struct packed {
      logic last;
   } mdu_status_type;

endpackage

`default_nettype wire

>>> rtl/core/mdu_datapath.sv
// Iterative shift/add-subtract datapath for multiply and restoring divide.
`default_nettype none

module mdu_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mdu_pkg::mdu_ctrl_type             ctrl,
   input  wire logic [mdu_pkg::MDU_WIDTH-1:0]     operand_s,
   input  wire logic [mdu_pkg::MDU_WIDTH-1:0]     operand_t,
   output mdu_pkg::mdu_status_type                status,
   output logic [mdu_pkg::MDU_WIDTH-1:0]          result_hi,
   output logic [mdu_pkg::MDU_WIDTH-1:0]          result_lo
);
   import mdu_pkg::*;

   localparam int W = MDU_WIDTH;

   logic [W-1:0]               acc_ff, acc_in;
   logic [W-1:0]               work_ff, work_in;
   logic [W-1:0]               opnd_ff, opnd_in;
   logic [MDU_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       is_div_ff, is_div_in;
   logic                       lo_neg_ff, lo_neg_in;
   logic                       rem_neg_ff, rem_neg_in;

   logic         s_neg, t_neg;
   logic [W-1:0] s_mag, t_mag;
   logic [W:0]   add_a, add_b, shifted;
   logic [W+1:0] sum;
   logic [2*W-1:0] product, product_neg;

   // Magnitudes of the operands for the signed forms
   always_comb begin
      s_neg = ctrl.is_signed & operand_s[W-1];
      t_neg = ctrl.is_signed & operand_t[W-1];
      s_mag = s_neg ? (~operand_s + {{(W-1){1'b0}}, 1'b1}) : operand_s;
      t_mag = t_neg ? (~operand_t + {{(W-1){1'b0}}, 1'b1}) : operand_t;
   end

   // Shared adder: partial-product add or trial subtract
   always_comb begin
      shifted = {acc_ff, work_ff[W-1]};
      if (is_div_ff) begin
         add_a = shifted;
         add_b = ~{1'b0, opnd_ff};
      end else begin
         add_a = {1'b0, acc_ff};
         add_b = work_ff[0] ? {1'b0, opnd_ff} : '0;
      end
      sum = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, is_div_ff};
   end

   // Load on start, advance one bit per step
   always_comb begin
      acc_in     = acc_ff;
      work_in    = work_ff;
      opnd_in    = opnd_ff;
      count_in   = count_ff;
      is_div_in  = is_div_ff;
      lo_neg_in  = lo_neg_ff;
      rem_neg_in = rem_neg_ff;
      if (ctrl.start) begin
         acc_in     = '0;
         work_in    = ctrl.is_div ? s_mag : t_mag;
         opnd_in    = ctrl.is_div ? t_mag : s_mag;
         count_in   = '0;
         is_div_in  = ctrl.is_div;
         lo_neg_in  = s_neg ^ t_neg;
         rem_neg_in = s_neg;
      end else if (ctrl.step) begin
         count_in = count_ff + {{(MDU_COUNT_WIDTH-1){1'b0}}, 1'b1};
         if (is_div_ff) begin
            if (sum[W+1]) begin
               acc_in  = sum[W-1:0];
               work_in = {work_ff[W-2:0], 1'b1};
            end else begin
               acc_in  = shifted[W-1:0];
               work_in = {work_ff[W-2:0], 1'b0};
            end
         end else begin
            acc_in  = sum[W:1];
            work_in = {sum[0], work_ff[W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      work_ff    <= work_in;
      opnd_ff    <= opnd_in;
      is_div_ff  <= is_div_in;
      lo_neg_ff  <= lo_neg_in;
      rem_neg_ff <= rem_neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.last = (count_ff == MDU_COUNT_WIDTH'(MDU_STEPS - 1));

   // Restore signs of product, quotient and remainder
   always_comb begin
      product     = {acc_ff, work_ff};
      product_neg = ~product + {{(2*W-1){1'b0}}, 1'b1};
      if (is_div_ff) begin
         result_lo = lo_neg_ff ? (~work_ff + {{(W-1){1'b0}}, 1'b1}) : work_ff;
         result_hi = rem_neg_ff ? (~acc_ff + {{(W-1){1'b0}}, 1'b1}) : acc_ff;
      end else if (lo_neg_ff) begin
         result_hi = product_neg[2*W-1:W];
         result_lo = product_neg[W-1:0];
      end else begin
         result_hi = product[2*W-1:W];
         result_lo = product[W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/mips_multiply_divide_unit_top.sv
// Top level of the MIPS HI/LO multiply-divide unit: sequencer, HI/LO and result register.
// MULT, MULTU, DIV, DIVU deliver their beat after acceptance once the ST_RUN state
// (32 passes through the shared 33-bit adder) and the ST_FIX sign-fix state are done;
// MFHI, MFLO, MTHI, MTLO deliver in the cycle after acceptance.
// Throughput: one register move per cycle while idle and unstalled; items never overlap.
// Reset: HI and LO load 0xdeadbeaf, no beat pending, sequencer idle.
`default_nettype none

module mips_multiply_divide_unit_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_operation,
   input  wire logic [mdu_pkg::MDU_WIDTH-1:0] req_operand_s,
   input  wire logic [mdu_pkg::MDU_WIDTH-1:0] req_operand_t,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mdu_pkg::MDU_WIDTH-1:0]      rsp_read_value,
   output logic [mdu_pkg::MDU_WIDTH-1:0]      rsp_hi_now,
   output logic [mdu_pkg::MDU_WIDTH-1:0]      rsp_lo_now
);
   import mdu_pkg::*;

   localparam int W = MDU_WIDTH;

   mdu_state_type  state_ff, state_in;
   mdu_ctrl_type   ctrl;
   mdu_status_type status;
   mdu_op_type     op;

   logic [W-1:0] hi_ff, hi_in;
   logic [W-1:0] lo_ff, lo_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [W-1:0] rsp_hi_now_ff, rsp_hi_now_in;
   logic [W-1:0] rsp_lo_now_ff, rsp_lo_now_in;
   logic [W-1:0] result_hi, result_lo;
   logic         accept, load;

   assign op        = mdu_op_type'(req_operation);
   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   mdu_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .operand_s (req_operand_s),
      .operand_t (req_operand_t),
      .status    (status),
      .result_hi (result_hi),
      .result_lo (result_lo)
   );

   // Sequence the item and update HI/LO
   always_comb begin
      state_in          = state_ff;
      ctrl              = '0;
      hi_in             = hi_ff;
      lo_in             = lo_ff;
      load              = 1'b0;
      rsp_read_value_in = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.is_div    = (op == OP_DIV) || (op == OP_DIVU);
            ctrl.is_signed = (op == OP_MULT) || (op == OP_DIV);
            if (accept) begin
               case (op) inside
                  OP_MULT, OP_MULTU, OP_DIV, OP_DIVU: begin
                     ctrl.start = 1'b1;
                     state_in   = ST_RUN;
                  end
                  OP_MFHI: begin
                     rsp_read_value_in = hi_ff;
                     load              = 1'b1;
                  end
                  OP_MFLO: begin
                     rsp_read_value_in = lo_ff;
                     load              = 1'b1;
                  end
                  OP_MTHI: begin
                     hi_in = req_operand_s;
                     load  = 1'b1;
                  end
                  default: begin
                     lo_in = req_operand_s;
                     load  = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            if (status.last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            hi_in    = result_hi;
            lo_in    = result_lo;
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result beat until taken
   always_comb begin
      rsp_hi_now_in = rsp_hi_now_ff;
      rsp_lo_now_in = rsp_lo_now_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_hi_now_in = hi_in;
         rsp_lo_now_in = lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hi_ff        <= MDU_RESET_VALUE;
         lo_ff        <= MDU_RESET_VALUE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_read_value_ff <= rsp_read_value_in;
      end
      rsp_hi_now_ff <= rsp_hi_now_in;
      rsp_lo_now_ff <= rsp_lo_now_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_hi_now     = rsp_hi_now_ff;
   assign rsp_lo_now     = rsp_lo_now_ff;

endmodule

`default_nettype wire

>>> rtl/core/mdu_checker.sv
// Port-level checks of the multiply-divide unit and their binding to the top level.
`default_nettype none

module mdu_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [2:0]                    req_operation,
   input wire logic [mdu_pkg::MDU_WIDTH-1:0] req_operand_s,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [mdu_pkg::MDU_WIDTH-1:0] rsp_read_value,
   input wire logic [mdu_pkg::MDU_WIDTH-1:0] rsp_hi_now,
   input wire logic [mdu_pkg::MDU_WIDTH-1:0] rsp_lo_now
);
   import mdu_pkg::*;

   logic req_beat;
   logic arith_op;

   assign req_beat = req_valid & ~req_stall;
   assign arith_op = (req_operation == OP_MULT) || (req_operation == OP_MULTU) ||
                     (req_operation == OP_DIV) || (req_operation == OP_DIVU);

   // Drop any pending beat on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   // Hold a stalled result beat
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hi_now) && $stable(rsp_lo_now)
         && $stable(rsp_read_value))
      else $error("stalled result beat changed");

   // Move to HI shows up in the very next beat
   a_mthi: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_operation == OP_MTHI) |=>
         rsp_valid && (rsp_hi_now == $past(req_operand_s)) && (rsp_read_value == '0))
      else $error("MTHI beat wrong");

   // Read of LO returns the LO it reports
   a_mflo: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_operation == OP_MFLO) |=>
         rsp_valid && (rsp_read_value == rsp_lo_now))
      else $error("MFLO beat wrong");

   // Arithmetic holds off both channels on the next cycle
   a_arith_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && arith_op |=> !rsp_valid && req_stall)
      else $error("arithmetic item finished too early");

endmodule

bind mips_multiply_divide_unit_top mdu_checker u_mdu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .req_operand_s  (req_operand_s),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value),
   .rsp_hi_now     (rsp_hi_now),
   .rsp_lo_now     (rsp_lo_now)
);

`default_nettype wire
